### src/adrp_pkg.sv
package adrp_pkg;

    // Byte offset counter width and its saturation value
    localparam int unsigned OFFSET_W = 11;
    localparam logic [OFFSET_W-1:0] OFFSET_MAX = '1;

    // Opcodes
    localparam logic [15:0] OP_DMX       = 16'h5000;
    localparam logic [15:0] OP_POLL      = 16'h2000;
    localparam logic [15:0] OP_POLLREPLY = 16'h2100;

    // Address mask and sequence wildcard
    localparam logic [15:0] NET_SUBNET_MASK = 16'h7FF0;
    localparam logic [7:0]  SEQ_ANY         = 8'hFF;

    // Result kinds
    localparam logic KIND_WRITE  = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    // Packet status codes
    typedef logic [3:0] t_status;
    localparam t_status ST_DMX_OK     = 4'd0;
    localparam t_status ST_POLL       = 4'd1;
    localparam t_status ST_POLLREPLY  = 4'd2;
    localparam t_status ST_OTHER_OP   = 4'd3;
    localparam t_status ST_SHORT      = 4'd4;
    localparam t_status ST_BAD_ID     = 4'd5;
    localparam t_status ST_SHORT_DMX  = 4'd6;
    localparam t_status ST_WRONG_ADDR = 4'd7;
    localparam t_status ST_BAD_SEQ    = 4'd8;
    localparam t_status ST_PORT_RANGE = 4'd9;

    // Result slots of one byte: eight slot writes, then the status
    localparam int unsigned RES_SLOTS  = 9;
    localparam int unsigned RES_STATUS = 8;
    localparam int unsigned RES_CUR    = 7;

    // Decisions the parser makes for the byte in the input register
    typedef struct packed {
        logic [RES_SLOTS-1:0] emit_mask;
        logic                 burst;
        logic [8:0]           single_chan;
        logic [1:0]           write_port;
        logic [15:0]          write_opcode;
        t_status              status;
        logic [1:0]           status_port;
        logic [15:0]          status_opcode;
    } t_parse_info;

    // Expected header: "Art-Net" and a zero terminator
    function automatic logic [7:0] art_id_byte(input logic [2:0] idx);
        logic [7:0] v;
        case (idx)
            3'd0: v = 8'h41;
            3'd1: v = 8'h72;
            3'd2: v = 8'h74;
            3'd3: v = 8'h2D;
            3'd4: v = 8'h4E;
            3'd5: v = 8'h65;
            3'd6: v = 8'h74;
            default: v = 8'h00;
        endcase
        return v;
    endfunction

endpackage

### src/adrp_parse.sv
module adrp_parse #(
    parameter int unsigned PORT_COUNT     = 4,
    parameter int unsigned UNIVERSE_SLOTS = 512
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_wr_en,
    input  logic [14:0]            i_cfg_wr_data,
    input  logic [7:0]             i_byte,
    input  logic                   i_eop,
    input  logic                   i_retire,
    input  logic [2:0]             i_rd_idx,
    output adrp_pkg::t_parse_info  o_info,
    output logic [7:0]             o_held_value
);

    localparam int unsigned PORT_W = (PORT_COUNT > 1) ? $clog2(PORT_COUNT) : 1;
    localparam int unsigned OW     = adrp_pkg::OFFSET_W;

    localparam logic [OW-1:0] OFF_OPC_LO  = OW'(8);
    localparam logic [OW-1:0] OFF_OPC_HI  = OW'(9);
    localparam logic [OW-1:0] OFF_MIN_HDR = OW'(11);
    localparam logic [OW-1:0] OFF_SEQ     = OW'(12);
    localparam logic [OW-1:0] OFF_UNI_LO  = OW'(14);
    localparam logic [OW-1:0] OFF_UNI_HI  = OW'(15);
    localparam logic [OW-1:0] OFF_LEN_HI  = OW'(16);
    localparam logic [OW-1:0] OFF_LEN_LO  = OW'(17);
    localparam logic [OW-1:0] OFF_DATA    = OW'(18);
    localparam logic [OW-1:0] OFF_HELD_HI = OW'(24);
    localparam logic [OW-1:0] OFF_RELEASE = OW'(25);

    // Per-packet state
    logic [OW-1:0] r_offset, n_offset;
    logic          r_id_ok, n_id_ok;
    logic [15:0]   r_opcode, n_opcode;
    logic [15:0]   r_universe, n_universe;
    logic [7:0]    r_seq, n_seq;
    logic [15:0]   r_decl_len, n_decl_len;
    logic          r_dmx_acc, n_dmx_acc;
    logic [14:0]   r_local_net;

    // Per-port sequence table and held first slots
    logic [7:0] r_last_seq [PORT_COUNT];
    logic [7:0] r_held [8];

    logic [3:0]        port_nib;
    logic [PORT_W-1:0] port_idx;
    logic [7:0]        last_seq;
    adrp_pkg::t_status verdict;
    logic              accept_rel;
    logic              held_wr;
    logic [OW-1:0]     chan_full;
    logic              single_ok;
    logic [7:0]        burst_bits;

    assign port_nib = r_universe[3:0];
    assign port_idx = port_nib[PORT_W-1:0];
    assign last_seq = r_last_seq[port_idx];

    // Judge address, port range and sequence, in that order
    always_comb begin
        if ((r_universe & adrp_pkg::NET_SUBNET_MASK) != {1'b0, r_local_net}) begin
            verdict = adrp_pkg::ST_WRONG_ADDR;
        end else if ({1'b0, port_nib} >= 5'(PORT_COUNT)) begin
            verdict = adrp_pkg::ST_PORT_RANGE;
        end else if ((r_seq <= last_seq) && (last_seq != adrp_pkg::SEQ_ANY)) begin
            verdict = adrp_pkg::ST_BAD_SEQ;
        end else begin
            verdict = adrp_pkg::ST_DMX_OK;
        end
    end

    assign accept_rel = (r_offset == OFF_RELEASE) && r_id_ok
                        && (r_opcode == adrp_pkg::OP_DMX)
                        && (verdict == adrp_pkg::ST_DMX_OK);
    assign held_wr    = (r_offset >= OFF_DATA) && (r_offset <= OFF_HELD_HI);

    // Capture header fields from the current byte
    always_comb begin
        n_offset   = r_offset;
        n_id_ok    = r_id_ok;
        n_opcode   = r_opcode;
        n_universe = r_universe;
        n_seq      = r_seq;
        n_decl_len = r_decl_len;
        n_dmx_acc  = r_dmx_acc;
        if (r_offset < OFF_OPC_LO) begin
            if (i_byte != adrp_pkg::art_id_byte(r_offset[2:0])) begin
                n_id_ok = 1'b0;
            end
        end else if (r_offset == OFF_OPC_LO) begin
            n_opcode[7:0] = i_byte;
        end else if (r_offset == OFF_OPC_HI) begin
            n_opcode[15:8] = i_byte;
        end else if (r_offset == OFF_SEQ) begin
            n_seq = i_byte;
        end else if (r_offset == OFF_UNI_LO) begin
            n_universe[7:0] = i_byte;
        end else if (r_offset == OFF_UNI_HI) begin
            n_universe[15:8] = i_byte;
        end else if (r_offset == OFF_LEN_HI) begin
            n_decl_len[15:8] = i_byte;
        end else if (r_offset == OFF_LEN_LO) begin
            n_decl_len[7:0] = i_byte;
        end else if (accept_rel) begin
            n_dmx_acc = 1'b1;
        end
        if (r_offset != adrp_pkg::OFFSET_MAX) begin
            n_offset = r_offset + OW'(1);
        end
    end

    // Decide which slot writes this byte releases
    assign chan_full = r_offset - OFF_DATA;
    assign single_ok = (r_offset > OFF_RELEASE) && r_dmx_acc
                       && ({5'd0, chan_full} < r_decl_len)
                       && (chan_full < OW'(UNIVERSE_SLOTS));

    always_comb begin
        for (int k = 0; k < 8; k++) begin
            burst_bits[k] = (16'(k) < r_decl_len) && (OW'(k) < OW'(UNIVERSE_SLOTS));
        end
    end

    always_comb begin
        o_info = '0;
        o_info.burst        = accept_rel;
        o_info.single_chan  = chan_full[8:0];
        o_info.write_port   = r_universe[1:0];
        o_info.write_opcode = r_opcode;
        o_info.emit_mask[adrp_pkg::RES_STATUS] = i_eop;
        if (accept_rel) begin
            o_info.emit_mask[7:0] = burst_bits;
        end else begin
            o_info.emit_mask[adrp_pkg::RES_CUR] = single_ok;
        end
        // End-of-packet status from the state after this byte
        o_info.status_opcode = n_opcode;
        if (r_offset < OFF_MIN_HDR) begin
            o_info.status        = adrp_pkg::ST_SHORT;
            o_info.status_opcode = '0;
        end else if (!n_id_ok) begin
            o_info.status        = adrp_pkg::ST_BAD_ID;
            o_info.status_opcode = '0;
        end else if (n_opcode == adrp_pkg::OP_POLL) begin
            o_info.status = adrp_pkg::ST_POLL;
        end else if (n_opcode == adrp_pkg::OP_POLLREPLY) begin
            o_info.status = adrp_pkg::ST_POLLREPLY;
        end else if (n_opcode != adrp_pkg::OP_DMX) begin
            o_info.status = adrp_pkg::ST_OTHER_OP;
        end else if (r_offset < OFF_RELEASE) begin
            o_info.status = adrp_pkg::ST_SHORT_DMX;
        end else if (n_dmx_acc) begin
            o_info.status      = adrp_pkg::ST_DMX_OK;
            o_info.status_port = r_universe[1:0];
        end else begin
            o_info.status = verdict;
        end
    end

    assign o_held_value = r_held[i_rd_idx];

    // Advance packet state when the byte retires; clear it at packet end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_offset    <= '0;
            r_id_ok     <= 1'b1;
            r_opcode    <= '0;
            r_universe  <= '0;
            r_seq       <= '0;
            r_decl_len  <= '0;
            r_dmx_acc   <= 1'b0;
            r_local_net <= '0;
            for (int p = 0; p < PORT_COUNT; p++) begin
                r_last_seq[p] <= 8'd1;
            end
        end else begin
            if (i_cfg_wr_en) begin
                r_local_net <= i_cfg_wr_data;
            end
            if (i_retire && accept_rel) begin
                r_last_seq[port_idx] <= r_seq;
            end
            if (i_retire) begin
                if (i_eop) begin
                    r_offset   <= '0;
                    r_id_ok    <= 1'b1;
                    r_opcode   <= '0;
                    r_universe <= '0;
                    r_seq      <= '0;
                    r_decl_len <= '0;
                    r_dmx_acc  <= 1'b0;
                end else begin
                    r_offset   <= n_offset;
                    r_id_ok    <= n_id_ok;
                    r_opcode   <= n_opcode;
                    r_universe <= n_universe;
                    r_seq      <= n_seq;
                    r_decl_len <= n_decl_len;
                    r_dmx_acc  <= n_dmx_acc;
                end
            end
        end
    end

    // Hold the first seven slots until the release byte
    always_ff @(posedge i_clk) begin
        if (i_retire && held_wr) begin
            r_held[chan_full[2:0]] <= i_byte;
        end
    end

endmodule

### src/artnet_dmx_receive_parser.sv
// An accepted byte waits in the input register; its results go one at a time to the output
// register. Throughput: one byte per cycle while each byte gives at most one result and the
// output does not stall; a byte holds the input register until its last result is sent, up
// to nine for the release byte of an accepted ArtDmx packet (eight slot writes and status).
// Reset: synchronous, active low; clears packet state, the address register and valids,
// and sets every per-port sequence entry to one.
module artnet_dmx_receive_parser #(
    parameter int unsigned PORT_COUNT     = 4,
    parameter int unsigned UNIVERSE_SLOTS = 512
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [14:0] i_cfg_wr_data,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_payload_byte,
    input  logic        i_end_of_packet,
    output logic        o_valid,
    input  logic        i_stall,
    output logic        o_result_kind,
    output logic [1:0]  o_universe_port,
    output logic [8:0]  o_channel_index,
    output logic [7:0]  o_slot_value,
    output logic [3:0]  o_packet_status,
    output logic [15:0] o_packet_opcode,
    output logic        o_last_of_run
);

    localparam int unsigned RS = adrp_pkg::RES_SLOTS;

    // Input register
    logic        r_stg_valid;
    logic [7:0]  r_stg_byte;
    logic        r_stg_eop;
    logic [RS-1:0] r_done;

    // Result register
    logic        r_out_valid;
    logic        r_kind;
    logic [1:0]  r_port;
    logic [8:0]  r_chan;
    logic [7:0]  r_value;
    logic [3:0]  r_status;
    logic [15:0] r_opcode;
    logic        r_last;

    adrp_pkg::t_parse_info info;
    logic [7:0]    held_value;
    logic [RS-1:0] remaining;
    logic [RS-1:0] pick_onehot;
    logic [3:0]    pick_idx;
    logic          pick_found;
    logic          is_last;
    logic          out_free;
    logic          emit;
    logic          retire;
    logic          in_acc;

    adrp_parse #(
        .PORT_COUNT     (PORT_COUNT),
        .UNIVERSE_SLOTS (UNIVERSE_SLOTS)
    ) u_parse (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_byte        (r_stg_byte),
        .i_eop         (r_stg_eop),
        .i_retire      (retire),
        .i_rd_idx      (pick_idx[2:0]),
        .o_info        (info),
        .o_held_value  (held_value)
    );

    // Pick the lowest result of this byte not yet sent
    assign remaining = info.emit_mask & ~r_done;

    always_comb begin
        pick_found = 1'b0;
        pick_idx   = '0;
        for (int k = RS - 1; k >= 0; k--) begin
            if (remaining[k]) begin
                pick_found = 1'b1;
                pick_idx   = 4'(k);
            end
        end
    end

    assign pick_onehot = RS'(1) << pick_idx;
    assign is_last     = (remaining & ~pick_onehot) == '0;

    // Handshake control
    assign out_free = !r_out_valid || !i_stall;
    assign emit     = r_stg_valid && pick_found && out_free;
    assign retire   = r_stg_valid && (!pick_found || (emit && is_last));
    assign o_stall  = r_stg_valid && !retire;
    assign in_acc   = i_valid && !o_stall;

    // Load the input register and track sent results
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stg_valid <= 1'b0;
            r_done      <= '0;
        end else begin
            if (in_acc) begin
                r_stg_valid <= 1'b1;
            end else if (retire) begin
                r_stg_valid <= 1'b0;
            end
            if (retire) begin
                r_done <= '0;
            end else if (emit) begin
                r_done <= r_done | pick_onehot;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_stg_byte <= i_payload_byte;
            r_stg_eop  <= i_end_of_packet;
        end
    end

    // Result register valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    // Result register payload: status or slot write
    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_last <= is_last;
            if (pick_idx == 4'(adrp_pkg::RES_STATUS)) begin
                r_kind   <= adrp_pkg::KIND_STATUS;
                r_port   <= info.status_port;
                r_chan   <= '0;
                r_value  <= '0;
                r_status <= info.status;
                r_opcode <= info.status_opcode;
            end else begin
                r_kind   <= adrp_pkg::KIND_WRITE;
                r_port   <= info.write_port;
                r_chan   <= info.burst ? {6'd0, pick_idx[2:0]} : info.single_chan;
                r_value  <= (pick_idx == 4'(adrp_pkg::RES_CUR)) ? r_stg_byte : held_value;
                r_status <= adrp_pkg::ST_DMX_OK;
                r_opcode <= info.write_opcode;
            end
        end
    end

    assign o_valid         = r_out_valid;
    assign o_result_kind   = r_kind;
    assign o_universe_port = r_port;
    assign o_channel_index = r_chan;
    assign o_slot_value    = r_value;
    assign o_packet_status = r_status;
    assign o_packet_opcode = r_opcode;
    assign o_last_of_run   = r_last;

    // A status result always closes its byte's run
    a_status_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_result_kind == adrp_pkg::KIND_STATUS)) |-> o_last_of_run)
        else $error("status result not marked last");

    // Only results of the current byte are ever marked sent
    a_done_in_mask: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_stg_valid |-> ((r_done & ~info.emit_mask) == '0))
        else $error("sent mask outside result mask");

    // Sent mask is clear while the input register is empty
    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_stg_valid |-> (r_done == '0))
        else $error("sent mask left over");

    // A retired byte leaves no sent results behind
    a_retire_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        retire |=> (r_done == '0))
        else $error("sent mask not cleared on retire");

    // Slot writes stay inside the universe
    a_chan_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_result_kind == adrp_pkg::KIND_WRITE))
            |-> ({1'b0, o_channel_index} < 10'(UNIVERSE_SLOTS)))
        else $error("slot write beyond universe");

endmodule
